[design/iass_pkg.sv]
// ----------------------------------------------------------------------------
// iass_pkg: shared definitions for the indexed word store with sort unit
// Field widths, command and status codes, and the structs that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package iass_pkg;

    localparam int DEPTH_DEFAULT = 1024;

    localparam int KIND_W   = 3;
    localparam int INDEX_W  = 10;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH = 3'd0,
        KIND_POP  = 3'd1,
        KIND_GET  = 3'd2,
        KIND_SET  = 3'd3,
        KIND_SORT = 3'd4
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_INDEX = 2'd1,
        STAT_FULL      = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_PUSH,
        DP_SET,
        DP_POP,
        DP_GET,
        DP_SORT_START,
        DP_SORT_LOAD,
        DP_SORT_RUN,
        DP_SORT_TAIL
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        logic    resp_load;
        logic    resp_mem;
        status_t resp_status;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic idx_ok;
        logic sortable;
        logic out_free;
        logic run_last;
        logic pass_again;
    } dp_stat_t;

endpackage

[design/iass_dp.sv]
// ----------------------------------------------------------------------------
// iass_dp: datapath of the indexed word store
// Word memory, fill count, bubble pass registers and the result register.
// ----------------------------------------------------------------------------
module iass_dp #(
    parameter int DEPTH = iass_pkg::DEPTH_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  iass_pkg::dp_cmd_t                    cmd,
    output iass_pkg::dp_stat_t                   stat,
    input  logic [iass_pkg::INDEX_W-1:0]         s_index,
    input  logic signed [iass_pkg::VALUE_W-1:0]  s_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [iass_pkg::STATUS_W-1:0]        m_status,
    output logic signed [iass_pkg::VALUE_W-1:0]  m_value_out,
    output logic [iass_pkg::COUNT_W-1:0]         m_count
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int IW    = iass_pkg::INDEX_W;
    localparam int XW    = (CW > IW) ? CW : IW;
    localparam int VW    = iass_pkg::VALUE_W;
    localparam int OCW   = iass_pkg::COUNT_W;

    logic signed [VW-1:0] store_mem [DEPTH];

    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [AW-1:0]        lim_reg;
    logic [AW-1:0]        lim_next;
    logic [AW-1:0]        j_reg;
    logic [AW-1:0]        j_next;
    logic signed [VW-1:0] carry_reg;
    logic signed [VW-1:0] carry_next;
    logic                 swapped_reg;
    logic                 swapped_next;
    logic signed [VW-1:0] rd_data_reg;

    logic                 out_valid_reg;
    logic [iass_pkg::STATUS_W-1:0] out_status_reg;
    logic signed [VW-1:0] out_value_reg;
    logic [OCW-1:0]       out_count_reg;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic signed [VW-1:0] wr_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 carry_gt;

    assign carry_gt = carry_reg > rd_data_reg;

    always_comb begin
        stat.full       = count_reg == CW'(DEPTH);
        stat.empty      = count_reg == '0;
        stat.idx_ok     = XW'(s_index) < XW'(count_reg);
        stat.sortable   = count_reg > CW'(1);
        stat.out_free   = !out_valid_reg || m_ready;
        stat.run_last   = j_reg == lim_reg;
        stat.pass_again = swapped_reg && (lim_reg != AW'(1));
    end

    always_comb begin
        count_next   = count_reg;
        lim_next     = lim_reg;
        j_next       = j_reg;
        carry_next   = carry_reg;
        swapped_next = swapped_reg;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = s_value;
        rd_en        = 1'b0;
        rd_addr      = '0;
        unique case (cmd.op)
            iass_pkg::DP_PUSH: begin
                wr_en      = 1'b1;
                wr_addr    = AW'(count_reg);
                count_next = count_reg + CW'(1);
            end
            iass_pkg::DP_SET: begin
                wr_en   = 1'b1;
                wr_addr = AW'(s_index);
            end
            iass_pkg::DP_POP: begin
                rd_en      = 1'b1;
                count_next = count_reg - CW'(1);
                rd_addr    = AW'(count_next);
            end
            iass_pkg::DP_GET: begin
                rd_en   = 1'b1;
                rd_addr = AW'(s_index);
            end
            iass_pkg::DP_SORT_START: begin
                rd_en        = 1'b1;
                lim_next     = AW'(count_reg - CW'(1));
                swapped_next = 1'b0;
            end
            iass_pkg::DP_SORT_LOAD: begin
                rd_en      = 1'b1;
                rd_addr    = AW'(1);
                j_next     = AW'(1);
                carry_next = rd_data_reg;
            end
            iass_pkg::DP_SORT_RUN: begin
                wr_en   = 1'b1;
                wr_addr = j_reg - AW'(1);
                if (carry_gt) begin
                    wr_data      = rd_data_reg;
                    swapped_next = 1'b1;
                end else begin
                    wr_data    = carry_reg;
                    carry_next = rd_data_reg;
                end
                if (j_reg != lim_reg) begin
                    rd_en   = 1'b1;
                    rd_addr = j_reg + AW'(1);
                    j_next  = j_reg + AW'(1);
                end
            end
            iass_pkg::DP_SORT_TAIL: begin
                wr_en        = 1'b1;
                wr_addr      = lim_reg;
                wr_data      = carry_reg;
                rd_en        = 1'b1;
                lim_next     = lim_reg - AW'(1);
                swapped_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (cmd.resp_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        lim_reg     <= lim_next;
        j_reg       <= j_next;
        carry_reg   <= carry_next;
        swapped_reg <= swapped_next;
        if (cmd.resp_load) begin
            out_status_reg <= cmd.resp_status;
            out_value_reg  <= cmd.resp_mem ? rd_data_reg : '0;
            out_count_reg  <= OCW'(count_next);
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_status    = out_status_reg;
    assign m_value_out = out_value_reg;
    assign m_count     = out_count_reg;

endmodule

[design/iass_ctrl.sv]
// ----------------------------------------------------------------------------
// iass_ctrl: controller of the indexed word store
// Decodes each command beat and sequences reads and bubble sort passes.
// ----------------------------------------------------------------------------
module iass_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [iass_pkg::KIND_W-1:0]   s_kind,
    input  iass_pkg::dp_stat_t            stat,
    output iass_pkg::dp_cmd_t             cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SORT_LOAD,
        ST_SORT_RUN,
        ST_SORT_TAIL
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE) && stat.out_free;

    always_comb begin
        state_next      = state_reg;
        cmd.op          = iass_pkg::DP_NONE;
        cmd.resp_load   = 1'b0;
        cmd.resp_mem    = 1'b0;
        cmd.resp_status = iass_pkg::STAT_OK;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && stat.out_free) begin
                    unique case (iass_pkg::kind_t'(s_kind))
                        iass_pkg::KIND_PUSH: begin
                            cmd.resp_load = 1'b1;
                            if (stat.full) begin
                                cmd.resp_status = iass_pkg::STAT_FULL;
                            end else begin
                                cmd.op = iass_pkg::DP_PUSH;
                            end
                        end
                        iass_pkg::KIND_POP: begin
                            if (stat.empty) begin
                                cmd.resp_load   = 1'b1;
                                cmd.resp_status = iass_pkg::STAT_BAD_INDEX;
                            end else begin
                                cmd.op     = iass_pkg::DP_POP;
                                state_next = ST_READ;
                            end
                        end
                        iass_pkg::KIND_GET: begin
                            if (!stat.idx_ok) begin
                                cmd.resp_load   = 1'b1;
                                cmd.resp_status = iass_pkg::STAT_BAD_INDEX;
                            end else begin
                                cmd.op     = iass_pkg::DP_GET;
                                state_next = ST_READ;
                            end
                        end
                        iass_pkg::KIND_SET: begin
                            cmd.resp_load = 1'b1;
                            if (!stat.idx_ok) begin
                                cmd.resp_status = iass_pkg::STAT_BAD_INDEX;
                            end else begin
                                cmd.op = iass_pkg::DP_SET;
                            end
                        end
                        iass_pkg::KIND_SORT: begin
                            if (stat.sortable) begin
                                cmd.op     = iass_pkg::DP_SORT_START;
                                state_next = ST_SORT_LOAD;
                            end else begin
                                cmd.resp_load = 1'b1;
                            end
                        end
                        default: begin
                            cmd.resp_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                cmd.resp_load = 1'b1;
                cmd.resp_mem  = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_SORT_LOAD: begin
                cmd.op     = iass_pkg::DP_SORT_LOAD;
                state_next = ST_SORT_RUN;
            end
            ST_SORT_RUN: begin
                cmd.op = iass_pkg::DP_SORT_RUN;
                if (stat.run_last) begin
                    state_next = ST_SORT_TAIL;
                end
            end
            ST_SORT_TAIL: begin
                cmd.op = iass_pkg::DP_SORT_TAIL;
                if (stat.pass_again) begin
                    state_next = ST_SORT_LOAD;
                end else begin
                    cmd.resp_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[design/indexed_array_store_with_sort_unit.sv]
// ----------------------------------------------------------------------------
// indexed_array_store_with_sort_unit: word store with push, pop, get, set, sort
// Fixed-depth store of signed words with a fill count and in-place sorting.
//
//   channel | direction | ports
//   s_      | in        | s_valid, s_ready, s_kind, s_index, s_value
//   m_      | out       | m_valid, m_ready, m_status, m_value_out, m_count
//
// Push, set and every failing command are answered from the idle state, so
// such beats can follow each other in consecutive cycles while results are
// taken. Pop and get pass through a read state because of the registered
// memory read. Sort over n entries starts with the accept beat and then runs
// its passes, each through a load, run and tail state, each later pass one
// entry shorter; the passes stop after the first one without a swap or once
// the pass limit reaches one. Reset clears the fill count and the result valid
// flag; the memory is not cleared. A stalled result blocks new input beats.
// ----------------------------------------------------------------------------
module indexed_array_store_with_sort_unit #(
    parameter int DEPTH = iass_pkg::DEPTH_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [iass_pkg::KIND_W-1:0]          s_kind,
    input  logic [iass_pkg::INDEX_W-1:0]         s_index,
    input  logic signed [iass_pkg::VALUE_W-1:0]  s_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [iass_pkg::STATUS_W-1:0]        m_status,
    output logic signed [iass_pkg::VALUE_W-1:0]  m_value_out,
    output logic [iass_pkg::COUNT_W-1:0]         m_count
);

    iass_pkg::dp_cmd_t  cmd;
    iass_pkg::dp_stat_t stat;

    iass_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .stat    (stat),
        .cmd     (cmd)
    );

    iass_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_index     (s_index),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_value_out (m_value_out),
        .m_count     (m_count)
    );

endmodule

[test/tb_indexed_array_store_with_sort_unit.sv]
// ----------------------------------------------------------------------------
// tb_indexed_array_store_with_sort_unit: self-checking bench for the word store
// Drives push, pop, get, set and sort commands through the input channel and
// predicts each result beat with a behavioral copy of the store and its fill
// count. Each result beat is checked field by field against the oldest
// prediction. The run has a directed opening and random traffic under three
// idling patterns with one long result stall. It ends with a sort of what the
// random traffic left in the store and a few reads.
// ----------------------------------------------------------------------------
module tb_indexed_array_store_with_sort_unit;

    localparam int KIND_W           = iass_pkg::KIND_W;
    localparam int INDEX_W          = iass_pkg::INDEX_W;
    localparam int VALUE_W          = iass_pkg::VALUE_W;
    localparam int STATUS_W         = iass_pkg::STATUS_W;
    localparam int COUNT_W          = iass_pkg::COUNT_W;
    localparam int DEPTH            = iass_pkg::DEPTH_DEFAULT;
    localparam int RANDOM_PER_PHASE = 255;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam logic signed [VALUE_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        iass_pkg::status_t          status;
        logic signed [VALUE_W-1:0]  word;
        logic [COUNT_W-1:0]         count;
    } store_result_t;

    class store_checker;
        logic signed [VALUE_W-1:0] words [DEPTH];
        int unsigned               fill;
        store_result_t             pending [$];
        int unsigned               failures;

        function void note_failure(string msg);
            failures++;
            if (failures <= 10) begin
                $display("%s", msg);
            end
        endfunction

        function void sort_words();
            logic signed [VALUE_W-1:0] held;
            bit                        swapped;
            int unsigned               pass;
            int unsigned               j;
            if (fill < 2) return;
            for (pass = 0; pass + 1 < fill; pass++) begin
                swapped = 1'b0;
                for (j = 0; j + 1 < fill; j++) begin
                    if (words[j] > words[j+1]) begin
                        held       = words[j];
                        words[j]   = words[j+1];
                        words[j+1] = held;
                        swapped    = 1'b1;
                    end
                end
                if (!swapped) break;
            end
        endfunction

        function void note_command(logic [KIND_W-1:0] kind, logic [INDEX_W-1:0] index,
                                   logic signed [VALUE_W-1:0] value);
            store_result_t r;
            r.status = iass_pkg::STAT_OK;
            r.word   = '0;
            case (kind)
                iass_pkg::KIND_PUSH: begin
                    if (fill >= DEPTH) begin
                        r.status = iass_pkg::STAT_FULL;
                    end else begin
                        words[fill] = value;
                        fill++;
                    end
                end
                iass_pkg::KIND_POP: begin
                    if (fill == 0) begin
                        r.status = iass_pkg::STAT_BAD_INDEX;
                    end else begin
                        fill--;
                        r.word = words[fill];
                    end
                end
                iass_pkg::KIND_GET: begin
                    if (index >= fill) begin
                        r.status = iass_pkg::STAT_BAD_INDEX;
                    end else begin
                        r.word = words[index];
                    end
                end
                iass_pkg::KIND_SET: begin
                    if (index >= fill) begin
                        r.status = iass_pkg::STAT_BAD_INDEX;
                    end else begin
                        words[index] = value;
                    end
                end
                iass_pkg::KIND_SORT: begin
                    sort_words();
                end
                default: begin
                end
            endcase
            r.count = COUNT_W'(fill);
            pending.push_back(r);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status,
                                   logic signed [VALUE_W-1:0] word,
                                   logic [COUNT_W-1:0] count);
            store_result_t want;
            if (pending.size() == 0) begin
                note_failure($sformatf("unexpected result beat: status %0d value %0d count %0d",
                                       status, word, count));
                return;
            end
            want = pending.pop_front();
            if (status !== want.status) begin
                note_failure($sformatf("status mismatch: expected %0d got %0d",
                                       want.status, status));
            end
            if (word !== want.word) begin
                note_failure($sformatf("value_out mismatch: expected %0d got %0d",
                                       want.word, word));
            end
            if (count !== want.count) begin
                note_failure($sformatf("count mismatch: expected %0d got %0d",
                                       want.count, count));
            end
        endfunction
    endclass

    logic                         aclk;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    logic [KIND_W-1:0]            s_kind;
    logic [INDEX_W-1:0]           s_index;
    logic signed [VALUE_W-1:0]    s_value;
    logic                         m_valid;
    logic                         m_ready;
    logic [STATUS_W-1:0]          m_status;
    logic signed [VALUE_W-1:0]    m_value_out;
    logic [COUNT_W-1:0]           m_count;

    store_checker chk;
    int unsigned  send_idle_pct;
    int unsigned  recv_idle_pct;
    bit           long_hold_request;

    indexed_array_store_with_sort_unit #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_kind     (s_kind),
        .s_index    (s_index),
        .s_value    (s_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_value_out(m_value_out),
        .m_count    (m_count)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    task automatic send_command(input logic [KIND_W-1:0] kind, input logic [INDEX_W-1:0] index,
                                input logic signed [VALUE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_index <= index;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
        chk.note_command(kind, index, value);
        @(negedge aclk);
    endtask

    task automatic send_random_command();
        logic [KIND_W-1:0]          kind;
        logic [INDEX_W-1:0]         index;
        logic signed [VALUE_W-1:0]  value;
        int unsigned                pick;
        int unsigned                push_share;
        push_share = (chk.fill < 6) ? 50 : (chk.fill > 40) ? 15 : 30;
        if ($urandom_range(99) < push_share) begin
            kind = iass_pkg::KIND_PUSH;
        end else begin
            pick = $urandom_range(99);
            if (pick < 30) kind = iass_pkg::KIND_POP;
            else if (pick < 58) kind = iass_pkg::KIND_GET;
            else if (pick < 84) kind = iass_pkg::KIND_SET;
            else if (pick < 97) kind = (chk.fill > 48) ? iass_pkg::KIND_POP
                                                        : iass_pkg::KIND_SORT;
            else kind = KIND_W'($urandom_range(7, 5));
        end
        pick = $urandom_range(9);
        if (pick < 7) index = INDEX_W'($urandom_range(chk.fill));
        else if (pick < 8) index = INDEX_W'(chk.fill);
        else index = INDEX_W'($urandom_range(DEPTH - 1));
        pick = $urandom_range(9);
        if (pick < 6) begin
            value = $urandom;
        end else if (pick < 8) begin
            value = $signed($urandom_range(20)) - 10;
        end else begin
            case ($urandom_range(3))
                0: value = WORD_MIN;
                1: value = WORD_MAX;
                2: value = '0;
                default: value = -1;
            endcase
        end
        send_command(kind, index, value);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            chk.check_result(m_status, m_value_out, m_count);
        end
    end

    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold_request) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge aclk);
                long_hold_request = 1'b0;
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        int phase;
        int n;
        chk               = new();
        aresetn           = 1'b0;
        s_valid           = 1'b0;
        s_kind            = '0;
        s_index           = '0;
        s_value           = '0;
        send_idle_pct     = 0;
        recv_idle_pct     = 0;
        long_hold_request = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // Commands on an empty store, then unused kinds, then pushes, gets, sets, a sort and pops.
        send_command(iass_pkg::KIND_POP, '0, '0);
        send_command(iass_pkg::KIND_GET, '0, '0);
        send_command(iass_pkg::KIND_SET, '0, 32'sd5);
        send_command(iass_pkg::KIND_SORT, '0, '0);
        send_command(3'd5, 10'd1, -1);
        send_command(3'd6, 10'd1023, WORD_MAX);
        send_command(3'd7, 10'd512, WORD_MIN);
        send_command(iass_pkg::KIND_PUSH, 10'd1023, WORD_MIN);
        send_command(iass_pkg::KIND_SORT, '0, '0);
        send_command(iass_pkg::KIND_PUSH, '0, WORD_MAX);
        send_command(iass_pkg::KIND_PUSH, '0, '0);
        send_command(iass_pkg::KIND_PUSH, '0, -1);
        send_command(iass_pkg::KIND_PUSH, '0, 32'sd1);
        send_command(iass_pkg::KIND_GET, 10'd0, '0);
        send_command(iass_pkg::KIND_GET, 10'd5, '0);
        send_command(iass_pkg::KIND_GET, 10'd1023, '0);
        send_command(iass_pkg::KIND_SET, 10'd3, 32'sh8000_0001);
        send_command(iass_pkg::KIND_SET, 10'd5, 32'sd77);
        send_command(iass_pkg::KIND_SORT, '0, '0);
        send_command(iass_pkg::KIND_GET, 10'd1, '0);
        send_command(iass_pkg::KIND_GET, 10'd4, '0);
        send_command(iass_pkg::KIND_POP, '0, '0);
        send_command(iass_pkg::KIND_POP, '0, '0);

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 13;
                    recv_idle_pct = 70;
                end
                1: begin
                    send_idle_pct = 70;
                    recv_idle_pct = 13;
                end
                default: begin
                    send_idle_pct     = 0;
                    recv_idle_pct     = 0;
                    long_hold_request = 1'b1;
                end
            endcase
            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                send_random_command();
            end
        end

        send_command(iass_pkg::KIND_SORT, '0, '0);
        send_command(iass_pkg::KIND_GET, 10'd0, '0);
        send_command(iass_pkg::KIND_GET, INDEX_W'(chk.fill - 1), '0);
        send_command(iass_pkg::KIND_GET, INDEX_W'(chk.fill), '0);
        send_command(iass_pkg::KIND_POP, '0, '0);
        send_command(iass_pkg::KIND_POP, '0, '0);
        s_valid <= 1'b0;

        while (chk.pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (chk.failures == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
